### sv/pbsa_pkg.sv
// ============================================================================
// pbsa_pkg
// shared types and constants of the paged bitmap slot allocator
// ============================================================================
package pbsa_pkg;

    localparam int SLOTS_PER_PAGE = 256;
    localparam int MAX_SLOTS      = 1024;

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 21;
    localparam int NUM_W     = 11;
    localparam int IDX_W     = 10;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WORDS     = MAX_SLOTS / WORD_BITS;
    localparam int WORD_W    = $clog2(WORDS);
    localparam int WPP       = SLOTS_PER_PAGE / WORD_BITS;
    localparam int WPP_W     = $clog2(WPP);
    localparam int MAX_PAGES = MAX_SLOTS / SLOTS_PER_PAGE;
    localparam int PG_W      = $clog2(MAX_PAGES);
    localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
    localparam int PAGE_SH   = $clog2(SLOTS_PER_PAGE);
    localparam int LEN_W     = $clog2(ADDR_W + 1);
    localparam int PROD_W    = IDX_W + SIZE_W;
    localparam int START_W   = 8;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam logic [WORD_BITS-1:0] WORD_ONES = 32'hFFFFFFFF;

    localparam logic [NUM_W-1:0]  RST_NUM_SLOTS = 11'd1024;
    localparam logic [SIZE_W-1:0] RST_SLOT_SIZE = 21'd64;
    localparam logic [ADDR_W-1:0] RST_BASE_ADDR = 48'd0;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_NUM_SLOTS = 2'd0,
        REG_SLOT_SIZE = 2'd1,
        REG_BASE_ADDR = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] slot;
    } t_bm_wr;

endpackage

### sv/pbsa_div.sv
// ============================================================================
// pbsa_div
// shared restoring divider, one quotient bit per cycle
// ============================================================================
module pbsa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pbsa_pkg::ADDR_W-1:0] i_dividend,
    input  logic [pbsa_pkg::LEN_W-1:0]  i_len,
    input  logic [pbsa_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [pbsa_pkg::ADDR_W-1:0] o_quot,
    output logic [pbsa_pkg::SIZE_W-1:0] o_rem
);
    import pbsa_pkg::*;

    logic [LEN_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_dvd;
    logic [ADDR_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W:0]   w_trial;
    logic              w_ge;

    // dividend arrives msb aligned, only i_len steps are run
    assign w_trial = {r_rem, r_dvd[ADDR_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_len;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - LEN_W'(1);
            r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
            r_quo <= {r_quo[ADDR_W-2:0], w_ge};
            r_rem <= w_ge ? SIZE_W'(w_trial - {1'b0, r_div}) : w_trial[SIZE_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

### sv/pbsa_bitmap.sv
// ============================================================================
// pbsa_bitmap
// used-bit word store with lowest free slot search in one word
// ============================================================================
module pbsa_bitmap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pbsa_pkg::WORD_W-1:0] i_rd_word,
    input  logic [pbsa_pkg::NUM_W-1:0]  i_n_live,
    input  pbsa_pkg::t_bm_wr            i_wr,
    output logic                        o_found,
    output logic [pbsa_pkg::BIT_W-1:0]  o_bit
);
    import pbsa_pkg::*;

    logic [WORD_BITS-1:0] r_words [WORDS];
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_free;
    logic [WORD_BITS-1:0] w_iso;
    logic [NUM_W-1:0]     w_wbase;
    logic [NUM_W-1:0]     w_diff;

    // only slots below the live count may be granted
    assign w_wbase = NUM_W'({i_rd_word, BIT_W'(0)});
    assign w_diff  = i_n_live - w_wbase;

    always_comb begin
        if (i_n_live <= w_wbase) begin
            w_mask = '0;
        end else if (w_diff >= NUM_W'(WORD_BITS)) begin
            w_mask = WORD_ONES;
        end else begin
            w_mask = ~(WORD_ONES << w_diff[BIT_W-1:0]);
        end
    end

    assign w_free = ~r_words[i_rd_word] & w_mask;
    assign w_iso  = w_free & (~w_free + WORD_BITS'(1));

    always_comb begin
        o_bit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w_iso[i]) begin
                o_bit = o_bit | BIT_W'(i);
            end
        end
    end

    assign o_found = |w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                r_words[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_words[i_wr.slot[IDX_W-1:BIT_W]][i_wr.slot[BIT_W-1:0]] <= i_wr.set;
        end
    end

endmodule

### sv/paged_bitmap_slot_allocator_unit.sv
// ============================================================================
// paged_bitmap_slot_allocator_unit
// fixed-size slot allocator over a paged used-bit map
// ============================================================================
// Requests enter on the s_axis channel: tuser is the kind (allocate or free),
// tdata carries the start page and the free address. Each request gives one
// result transaction on m_axis: tuser is the status, tdata the slot address
// and slot index. The block takes one request at a time; s_axis_tready is
// high only while the sequencer is idle.
// A free runs 48 steps of the shared divider, over the offset from the
// base address. An allocate runs 8 divider steps for the start page, then
// enters the scan and scans one bitmap word at a time (up to 32 words),
// then does the address multiply, add and result. An allocate on an empty
// pool skips the divider and goes straight to the result with status full.
// The result waits in an output register; when the receiver stalls, the
// next request can be accepted and worked, and its result is held back
// until the output register is taken.
// Registers on the APB port: num_slots at 0x00, slot_size at 0x08,
// base_address at 0x10. Reset clears the bit store (every slot free) and
// loads the register defaults.
// ============================================================================
module paged_bitmap_slot_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [55:0]                  s_axis_tdata,  // start_page, free_address
    input  logic [0:0]                   s_axis_tuser,  // kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [63:0]                  m_axis_tdata,  // slot_address, slot_index
    output logic [1:0]                   m_axis_tuser,  // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbsa_pkg::PADDR_W-1:0] paddr,
    input  logic [pbsa_pkg::PDATA_W-1:0] pwdata,
    output logic [pbsa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import pbsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_RES
    } t_state;

    t_state              r_state;
    logic [NUM_W-1:0]    r_num_slots;
    logic [SIZE_W-1:0]   r_slot_size;
    logic [ADDR_W-1:0]   r_base;
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_faddr;
    logic [PG_W-1:0]     r_pg;
    logic [WPP_W-1:0]    r_wcnt;
    logic [PCNT_W-1:0]   r_pcnt;
    logic [IDX_W-1:0]    r_idx;
    logic [PROD_W-1:0]   r_prod;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_m_valid;
    t_status             r_m_status;
    logic [ADDR_W-1:0]   r_m_addr;
    logic [IDX_W-1:0]    r_m_idx;

    logic [NUM_W-1:0]    w_n_live;
    logic [SIZE_W-1:0]   w_size;
    logic [NUM_W-1:0]    w_pg_sum;
    logic [PCNT_W-1:0]   w_pages;
    logic                w_in_acc;
    logic                w_cfg_wr;
    logic                w_div_start;
    logic [ADDR_W-1:0]   w_dividend;
    logic [LEN_W-1:0]    w_len;
    logic [SIZE_W-1:0]   w_divisor;
    logic                w_div_busy;
    logic [ADDR_W-1:0]   w_quot;
    logic [SIZE_W-1:0]   w_rem;
    logic                w_q_ok;
    logic [WORD_W-1:0]   w_rd_word;
    logic                w_found;
    logic [BIT_W-1:0]    w_bit;
    t_bm_wr              w_bm_wr;
    logic [PG_W-1:0]     w_pg_inc;

    assign w_n_live = (r_num_slots > NUM_W'(MAX_SLOTS)) ? NUM_W'(MAX_SLOTS) : r_num_slots;
    assign w_size   = (r_slot_size == '0) ? SIZE_W'(1) : r_slot_size;
    assign w_pg_sum = w_n_live + NUM_W'(SLOTS_PER_PAGE - 1);
    assign w_pages  = PCNT_W'(w_pg_sum >> PAGE_SH);

    assign s_axis_tready = r_state == S_IDLE;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // divider: start page modulo page count, or offset over slot size
    assign w_div_start = w_in_acc && (t_kind'(s_axis_tuser[0]) == KIND_FREE || w_pages != '0);
    always_comb begin
        if (t_kind'(s_axis_tuser[0]) == KIND_FREE) begin
            w_dividend = s_axis_tdata[55:8] - r_base;
            w_len      = LEN_W'(ADDR_W);
            w_divisor  = w_size;
        end else begin
            w_dividend = {s_axis_tdata[START_W-1:0], (ADDR_W-START_W)'(0)};
            w_len      = LEN_W'(START_W);
            w_divisor  = SIZE_W'(w_pages);
        end
    end

    pbsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_len      (w_len),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_q_ok    = w_quot < ADDR_W'(w_n_live);
    assign w_rd_word = {r_pg, r_wcnt};
    assign w_pg_inc  = (PCNT_W'(r_pg) + PCNT_W'(1) == w_pages) ? '0 : r_pg + PG_W'(1);

    always_comb begin
        w_bm_wr = '0;
        if (r_state == S_SCAN && w_found) begin
            w_bm_wr.en   = 1'b1;
            w_bm_wr.set  = 1'b1;
            w_bm_wr.slot = {w_rd_word, w_bit};
        end else if (r_state == S_DIV && !w_div_busy && r_kind == KIND_FREE && w_q_ok) begin
            w_bm_wr.en   = 1'b1;
            w_bm_wr.set  = 1'b0;
            w_bm_wr.slot = w_quot[IDX_W-1:0];
        end
    end

    pbsa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_word (w_rd_word),
        .i_n_live  (w_n_live),
        .i_wr      (w_bm_wr),
        .o_found   (w_found),
        .o_bit     (w_bit)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_NUM_SLOTS: prdata = PDATA_W'(r_num_slots);
            REG_SLOT_SIZE: prdata = PDATA_W'(r_slot_size);
            REG_BASE_ADDR: prdata = PDATA_W'(r_base);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slots <= RST_NUM_SLOTS;
            r_slot_size <= RST_SLOT_SIZE;
            r_base      <= RST_BASE_ADDR;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_NUM_SLOTS: r_num_slots <= pwdata[NUM_W-1:0];
                REG_SLOT_SIZE: r_slot_size <= pwdata[SIZE_W-1:0];
                REG_BASE_ADDR: r_base      <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && r_state != S_RES) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind  <= t_kind'(s_axis_tuser[0]);
                        r_faddr <= s_axis_tdata[55:8];
                        if (t_kind'(s_axis_tuser[0]) == KIND_ALLOC && w_pages == '0) begin
                            r_status <= ST_FULL;
                            r_addr   <= '0;
                            r_idx    <= '0;
                            r_state  <= S_RES;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        if (r_kind == KIND_ALLOC) begin
                            r_pg    <= w_rem[PG_W-1:0];
                            r_wcnt  <= '0;
                            r_pcnt  <= '0;
                            r_state <= S_SCAN;
                        end else if (w_q_ok) begin
                            r_status <= ST_OK;
                            r_idx    <= w_quot[IDX_W-1:0];
                            r_addr   <= r_faddr - ADDR_W'(w_rem);
                            r_state  <= S_RES;
                        end else begin
                            r_status <= ST_BAD;
                            r_idx    <= '0;
                            r_addr   <= '0;
                            r_state  <= S_RES;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_found) begin
                        r_idx   <= {w_rd_word, w_bit};
                        r_state <= S_MUL;
                    end else if (r_wcnt == WPP_W'(WPP - 1)) begin
                        r_wcnt <= '0;
                        if (r_pcnt == w_pages - PCNT_W'(1)) begin
                            r_status <= ST_FULL;
                            r_idx    <= '0;
                            r_addr   <= '0;
                            r_state  <= S_RES;
                        end else begin
                            r_pcnt <= r_pcnt + PCNT_W'(1);
                            r_pg   <= w_pg_inc;
                        end
                    end else begin
                        r_wcnt <= r_wcnt + WPP_W'(1);
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_idx) * PROD_W'(w_size);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_status <= ST_OK;
                    r_addr   <= r_base + ADDR_W'(r_prod);
                    r_state  <= S_RES;
                end
                S_RES: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_status;
                        r_m_addr   <= r_addr;
                        r_m_idx    <= r_idx;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(64 - IDX_W - ADDR_W)'(0), r_m_idx, r_m_addr};
    assign m_axis_tuser  = r_m_status;

endmodule
